>>> rtl/core/swept_aabb_collision_macros.svh
// Assertion macros used by the checker file.
`ifndef SWEPT_AABB_COLLISION_MACROS_SVH
`define SWEPT_AABB_COLLISION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swept_aabb_collision check failed");

// Next-cycle implication, disabled during reset.
`define SWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swept_aabb_collision check failed");

`endif

>>> rtl/core/swa_pkg.sv
// Shared constants for the swept box collision block.
`default_nettype none
package swa_pkg;
  localparam int COORD_WIDTH_DEF    = 24;
  localparam int TIME_FRAC_BITS_DEF = 16;

  localparam logic signed [1:0] NORM_NONE = 2'sb00;
  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;
endpackage
`default_nettype wire

>>> rtl/core/swept_aabb_collision.sv
// Swept box collision test: broad phase, slab times, hit check, entry time division.
// One transaction in and one result out per box pair, at a sustained rate of one per clock
// while out_stall is low. One stage forms swept bounds and slab numerators and
// denominators, one holds the four cross products, one picks entry and exit and decides
// the hit, and then a restoring divider makes one quotient bit per stage, in
// TIME_FRAC_BITS + 1 stages. Stages advance independently, so bubbles collapse and
// in_stall rises only when every stage holds a transaction.
// Coordinates are signed Q16.8 at the default width; entry_time is unsigned
// Q1.TIME_FRAC_BITS truncated toward zero; every field of a miss is zero.
`default_nettype none
module swept_aabb_collision #(
  parameter int COORD_WIDTH    = swa_pkg::COORD_WIDTH_DEF,
  parameter int TIME_FRAC_BITS = swa_pkg::TIME_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] mover_left,
  input  wire logic signed [COORD_WIDTH-1:0] mover_top,
  input  wire logic signed [COORD_WIDTH-1:0] mover_right,
  input  wire logic signed [COORD_WIDTH-1:0] mover_bottom,
  input  wire logic signed [COORD_WIDTH-1:0] shift_x,
  input  wire logic signed [COORD_WIDTH-1:0] shift_y,
  input  wire logic signed [COORD_WIDTH-1:0] still_left,
  input  wire logic signed [COORD_WIDTH-1:0] still_top,
  input  wire logic signed [COORD_WIDTH-1:0] still_right,
  input  wire logic signed [COORD_WIDTH-1:0] still_bottom,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic [TIME_FRAC_BITS:0]            entry_time,
  output logic signed [1:0]                  normal_x,
  output logic signed [1:0]                  normal_y
);
  localparam int CW = COORD_WIDTH;
  localparam int F  = TIME_FRAC_BITS;
  localparam int W1 = CW + 1;        // edge differences, denominators
  localparam int NW = CW + 2;        // signed numerators
  localparam int PW = NW + W1;       // cross products
  localparam int DS = F + 1;         // divider stages
  localparam int N  = 3 + DS;        // total stages

  // ---------------- stage occupancy and flow control ----------------
  logic [N-1:0] v;
  logic [N:0]   adv;

  always_comb begin
    adv[N] = !out_stall;
    for (int i = N - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------- stage 1: swept bounds, slab numerators ----------------
  logic signed [W1-1:0] ml, mt, mr, mb, dx, dy, sl, st, sr, sb;
  logic signed [W1-1:0] bl, br, bt, bb, ax, bx, ay, by;
  logic                 dxz, dyz, dxp, dyp, miss;

  always_comb begin
    ml = W1'(mover_left);   mt = W1'(mover_top);
    mr = W1'(mover_right);  mb = W1'(mover_bottom);
    dx = W1'(shift_x);      dy = W1'(shift_y);
    sl = W1'(still_left);   st = W1'(still_top);
    sr = W1'(still_right);  sb = W1'(still_bottom);
    dxz = (shift_x == '0);
    dyz = (shift_y == '0);
    dxp = !shift_x[CW-1] && !dxz;
    dyp = !shift_y[CW-1] && !dyz;
    bl = dxp ? ml : ml + dx;
    br = dxp ? mr + dx : mr;
    bt = dyp ? mt + dy : mt;
    bb = dyp ? mb : mb + dy;
    miss = (br < sl) || (bl > sr) || (bb > st) || (bt < sb);
    ax = sl - mr;  bx = sr - ml;
    ay = sb - mt;  by = st - mb;
  end

  logic                 s1_nohit, s1_xz, s1_yz, s1_dxp, s1_dyp;
  logic signed [NW-1:0] s1_nxe, s1_nxx, s1_nye, s1_nyx;
  logic signed [W1-1:0] s1_denx, s1_deny;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_nohit <= miss || (dxz && dyz);
      s1_xz    <= dxz;
      s1_yz    <= dyz;
      s1_dxp   <= dxp;
      s1_dyp   <= dyp;
      s1_nxe   <= dxp ? NW'(ax) : -NW'(bx);
      s1_nxx   <= dxp ? NW'(bx) : -NW'(ax);
      s1_nye   <= dyp ? NW'(ay) : -NW'(by);
      s1_nyx   <= dyp ? NW'(by) : -NW'(ay);
      s1_denx  <= dxp ? dx : -dx;
      s1_deny  <= dyp ? dy : -dy;
    end
  end

  // ---------------- stage 2: cross products ----------------
  logic                 s2_nohit, s2_xz, s2_yz, s2_dxp, s2_dyp;
  logic signed [NW-1:0] s2_nxe, s2_nxx, s2_nye, s2_nyx;
  logic signed [W1-1:0] s2_denx, s2_deny;
  logic signed [PW-1:0] s2_pexy, s2_peyx, s2_pxxy, s2_pxyx;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_nohit <= s1_nohit;
      s2_xz    <= s1_xz;
      s2_yz    <= s1_yz;
      s2_dxp   <= s1_dxp;
      s2_dyp   <= s1_dyp;
      s2_nxe   <= s1_nxe;
      s2_nxx   <= s1_nxx;
      s2_nye   <= s1_nye;
      s2_nyx   <= s1_nyx;
      s2_denx  <= s1_denx;
      s2_deny  <= s1_deny;
      s2_pexy  <= PW'(s1_nxe) * PW'(s1_deny);   // x entry scaled
      s2_peyx  <= PW'(s1_nye) * PW'(s1_denx);   // y entry scaled
      s2_pxxy  <= PW'(s1_nxx) * PW'(s1_deny);   // x exit scaled
      s2_pxyx  <= PW'(s1_nyx) * PW'(s1_denx);   // y exit scaled
    end
  end

  // ---------------- stage 3: entry/exit selection, hit decision ----------------
  logic                 x_later, x_exits_first, ent_neg, ent_gt1, ent_gt_ext, hit_c;
  logic signed [NW-1:0] ent_num;
  logic signed [W1-1:0] ent_den;

  always_comb begin
    // zero-displacement axis: entry -inf, exit +inf
    if (s2_xz)      x_later = 1'b0;
    else if (s2_yz) x_later = 1'b1;
    else            x_later = s2_pexy > s2_peyx;
    if (s2_xz)      x_exits_first = 1'b0;
    else if (s2_yz) x_exits_first = 1'b1;
    else            x_exits_first = s2_pxxy < s2_pxyx;

    ent_num = x_later ? s2_nxe : s2_nye;
    ent_den = x_later ? s2_denx : s2_deny;
    ent_neg = ent_num < 0;
    ent_gt1 = ent_num > NW'(ent_den);

    priority if (x_later && x_exits_first) begin
      ent_gt_ext = s2_nxe > s2_nxx;
    end else if (x_later) begin
      ent_gt_ext = !s2_yz && (s2_pexy > s2_pxyx);
    end else if (x_exits_first) begin
      ent_gt_ext = s2_peyx > s2_pxxy;
    end else begin
      ent_gt_ext = s2_nye > s2_nyx;
    end

    hit_c = !s2_nohit && !ent_neg && !ent_gt1 && !ent_gt_ext;
  end

  logic                 s3_hit;
  logic signed [1:0]    s3_nx, s3_ny;
  logic [CW-1:0]        s3_num, s3_den;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_hit <= hit_c;
      s3_nx  <= (hit_c && x_later) ? (s2_dxp ? swa_pkg::NORM_NEG : swa_pkg::NORM_POS)
                                   : swa_pkg::NORM_NONE;
      s3_ny  <= (hit_c && !x_later) ? (s2_dyp ? swa_pkg::NORM_NEG : swa_pkg::NORM_POS)
                                    : swa_pkg::NORM_NONE;
      s3_num <= ent_num[CW-1:0];
      s3_den <= ent_den[CW-1:0];
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic [F:0]        dv_q   [DS];
  logic [CW-1:0]     dv_r   [DS];
  logic [CW-1:0]     dv_den [DS];
  logic              dv_hit [DS];
  logic signed [1:0] dv_nx  [DS];
  logic signed [1:0] dv_ny  [DS];

  // first step: integer bit, numerator never exceeds denominator on a hit
  logic d0_b;
  assign d0_b = s3_num >= s3_den;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      dv_q[0]   <= {{F{1'b0}}, d0_b};
      dv_r[0]   <= d0_b ? s3_num - s3_den : s3_num;
      dv_den[0] <= s3_den;
      dv_hit[0] <= s3_hit;
      dv_nx[0]  <= s3_nx;
      dv_ny[0]  <= s3_ny;
    end
  end

  for (genvar k = 1; k < DS; k++) begin : g_div
    logic [CW:0] r2, dd;
    logic        b;
    always_comb begin
      r2 = {dv_r[k-1], 1'b0};
      dd = {1'b0, dv_den[k-1]};
      b  = r2 >= dd;
    end
    always_ff @(posedge clk) begin
      if (adv[3+k]) begin
        dv_q[k]   <= {dv_q[k-1][F-1:0], b};
        dv_r[k]   <= b ? CW'(r2 - dd) : CW'(r2);
        dv_den[k] <= dv_den[k-1];
        dv_hit[k] <= dv_hit[k-1];
        dv_nx[k]  <= dv_nx[k-1];
        dv_ny[k]  <= dv_ny[k-1];
      end
    end
  end

  // ---------------- output ----------------
  assign out_valid  = v[N-1];
  assign hit        = dv_hit[DS-1];
  assign entry_time = dv_hit[DS-1] ? dv_q[DS-1] : '0;
  assign normal_x   = dv_nx[DS-1];
  assign normal_y   = dv_ny[DS-1];
endmodule
`default_nettype wire

>>> rtl/core/swa_checker.sv
// Port-level checker for the swept box collision block, with its bind.
`default_nettype none
`include "swept_aabb_collision_macros.svh"
module swa_checker #(
  parameter int TIME_FRAC_BITS = swa_pkg::TIME_FRAC_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    hit,
  input wire logic [TIME_FRAC_BITS:0] entry_time,
  input wire logic signed [1:0]       normal_x,
  input wire logic signed [1:0]       normal_y
);
  // a miss reports all-zero fields
  `SWA_ASSERT_IMPLY(a_miss_zero, clk, rst, out_valid && !hit, (entry_time == '0) && (normal_x == swa_pkg::NORM_NONE) && (normal_y == swa_pkg::NORM_NONE))
  // a hit has exactly one unit normal component
  `SWA_ASSERT_IMPLY(a_hit_normal, clk, rst, out_valid && hit, ((normal_x == swa_pkg::NORM_NONE) != (normal_y == swa_pkg::NORM_NONE)) && (normal_x != 2'sb10) && (normal_y != 2'sb10))
  // entry time never exceeds one
  `SWA_ASSERT_IMPLY(a_time_range, clk, rst, out_valid, !entry_time[TIME_FRAC_BITS] || (entry_time[TIME_FRAC_BITS-1:0] == '0))
  // an empty output stage means the pipeline can take input
  `SWA_ASSERT_IMPLY(a_no_false_stall, clk, rst, !out_valid, !in_stall)
  // a stalled result stays
  `SWA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(entry_time) && $stable(hit))
endmodule

bind swept_aabb_collision swa_checker #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_swa_checker (.*);
`default_nettype wire

>>> tb/sv/tb_swept_aabb_collision.sv
// Testbench for the swept box collision block: directed table, random pairs, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_swept_aabb_collision;
  localparam int CW = swa_pkg::COORD_WIDTH_DEF;
  localparam int TF = swa_pkg::TIME_FRAC_BITS_DEF;
  localparam int LATENCY = TF + 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1730;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // one box pair: mover edges, displacement, static edges
  typedef struct packed {
    logic signed [CW-1:0] ml, mt, mr, mb, dx, dy, sl, st, sr, sb;
  } pair_t;

  typedef struct packed {
    logic          hit;
    logic [TF:0]   tentry;
    logic signed [1:0] nx, ny;
  } contact_t;

  // directed row: pair, plus a typed-in expectation where it is obvious
  typedef struct packed {
    pair_t    p;
    logic     fixed;
    contact_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_taken = 1'b0;  // input transaction accepted at the last rising edge
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [TF:0] entry_time;
  logic signed [1:0] normal_x, normal_y;
  pair_t drv = '0;

  contact_t pending_contacts[$];
  int errors = 0;
  int cycles = 0;
  // idle percentages for the sender and the receiver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;  // long receiver hold-off, counted down in its own process

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  swept_aabb_collision u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mover_left(drv.ml), .mover_top(drv.mt), .mover_right(drv.mr), .mover_bottom(drv.mb),
    .shift_x(drv.dx), .shift_y(drv.dy),
    .still_left(drv.sl), .still_top(drv.st), .still_right(drv.sr), .still_bottom(drv.sb),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .entry_time(entry_time), .normal_x(normal_x), .normal_y(normal_y)
  );

  // exact rational slab time; kind -1 / +1 mark minus / plus infinity
  typedef struct {
    int          kind;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } slab_t;

  function automatic int slab_cmp(slab_t a, slab_t b);
    logic signed [127:0] l, r;
    if (a.kind != 0 || b.kind != 0) begin
      if (a.kind == b.kind) return 0;
      return (a.kind < b.kind) ? -1 : 1;
    end
    l = a.num * b.den;
    r = b.num * a.den;
    return (l < r) ? -1 : ((l > r) ? 1 : 0);
  endfunction

  // entry/exit of one axis from displacement and the two gap distances
  function automatic void slab_span(input logic signed [63:0] d, near_gap, far_gap,
                                    output slab_t t_in, output slab_t t_out);
    t_in.kind = 0; t_out.kind = 0;
    if (d == 0) begin
      t_in.kind = -1; t_out.kind = 1;
      t_in.num = 0; t_in.den = 1; t_out.num = 0; t_out.den = 1;
    end else if (d > 0) begin
      t_in.num = near_gap; t_out.num = far_gap; t_in.den = d; t_out.den = d;
    end else begin
      t_in.num = -near_gap; t_out.num = -far_gap; t_in.den = -d; t_out.den = -d;
    end
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    logic signed [63:0] ml, mt, mr, mb, dx, dy, sl, st, sr, sb, bl, br, bt, bb;
    slab_t xe, xx, ye, yx, ent, ext, zero, one;
    logic [63:0] q;
    contact_t c;
    c = '0;
    ml = p.ml; mt = p.mt; mr = p.mr; mb = p.mb; dx = p.dx; dy = p.dy;
    sl = p.sl; st = p.st; sr = p.sr; sb = p.sb;
    bl = (dx > 0) ? ml : ml + dx;
    br = (dx > 0) ? mr + dx : mr;
    bt = (dy > 0) ? mt + dy : mt;
    bb = (dy > 0) ? mb : mb + dy;
    if (br < sl || bl > sr || bb > st || bt < sb) return c;
    if (dx == 0 && dy == 0) return c;
    if (dx > 0) slab_span(dx, sl - mr, sr - ml, xe, xx);
    else        slab_span(dx, sr - ml, sl - mr, xe, xx);
    if (dy > 0) slab_span(dy, sb - mt, st - mb, ye, yx);
    else        slab_span(dy, st - mb, sb - mt, ye, yx);
    zero.kind = 0; zero.num = 0; zero.den = 1;
    one.kind = 0;  one.num = 1;  one.den = 1;
    ent = (slab_cmp(xe, ye) > 0) ? xe : ye;
    ext = (slab_cmp(xx, yx) < 0) ? xx : yx;
    if (slab_cmp(ent, zero) < 0 || slab_cmp(ent, one) > 0) return c;
    if (slab_cmp(ent, ext) > 0 || ent.kind != 0) return c;
    q = (ent.num << TF) / ent.den;
    c.hit = 1'b1;
    c.tentry = q[TF:0];
    // later-entered axis gives the normal; a tie goes to y
    if (slab_cmp(xe, ye) > 0) c.nx = (dx > 0) ? swa_pkg::NORM_NEG : swa_pkg::NORM_POS;
    else                      c.ny = (dy > 0) ? swa_pkg::NORM_NEG : swa_pkg::NORM_POS;
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // input acceptance, read by the sender at the following falling edge
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // result side: compare each accepted transaction with the oldest expectation
  always @(posedge clk) begin
    contact_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("unexpected result", 64'({hit, entry_time}), 64'(0));
      end else begin
        w = pending_contacts.pop_front();
        if (hit !== w.hit) report_mismatch("hit", 64'(hit), 64'(w.hit));
        if (entry_time !== w.tentry)
          report_mismatch("entry_time", 64'(entry_time), 64'(w.tentry));
        if (normal_x !== w.nx) report_mismatch("normal_x", 64'(normal_x), 64'(w.nx));
        if (normal_y !== w.ny) report_mismatch("normal_y", 64'(normal_y), 64'(w.ny));
      end
    end
  end

  // receiver stall, changed at the falling edge
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // present one pair and wait until it is accepted; returns at a falling edge
  task automatic send_pair(pair_t p, logic fixed, contact_t want);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drv <= p;
    in_valid <= 1'b1;
    pending_contacts = {pending_contacts, (fixed ? want : predict_contact(p))};
    do @(negedge clk); while (!in_taken);
  endtask

  function automatic logic signed [CW-1:0] rnd_coord(int span);
    int v;
    v = $urandom_range(2 * span) - span;
    return CW'(v);
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    logic signed [CW-1:0] w, h;
    int mode, span;
    mode = $urandom_range(9);
    if (mode == 0) begin
      // raw noise over the whole range, edges possibly inverted
      p.ml = CW'($urandom); p.mt = CW'($urandom); p.mr = CW'($urandom);
      p.mb = CW'($urandom); p.dx = CW'($urandom); p.dy = CW'($urandom);
      p.sl = CW'($urandom); p.st = CW'($urandom); p.sr = CW'($urandom);
      p.sb = CW'($urandom);
      return p;
    end
    span = (mode < 7) ? 4096 : 2000000;
    p.sl = rnd_coord(span); p.sb = rnd_coord(span);
    w = CW'($urandom_range(span / 2)); h = CW'($urandom_range(span / 2));
    p.sr = p.sl + w; p.st = p.sb + h;
    p.ml = rnd_coord(span); p.mb = rnd_coord(span);
    w = CW'($urandom_range(span / 4)); h = CW'($urandom_range(span / 4));
    p.mr = p.ml + w; p.mt = p.mb + h;
    // aim toward the static box most of the time
    p.dx = (p.sl - p.ml) + rnd_coord(span / 4);
    p.dy = (p.sb - p.mb) + rnd_coord(span / 4);
    if ($urandom_range(7) == 0) p.dx = 0;
    if ($urandom_range(7) == 0) p.dy = 0;
    return p;
  endfunction

  function automatic pair_t mk(int ml, mt, mr, mb, dx, dy, sl, st, sr, sb);
    pair_t p;
    p.ml = CW'(ml); p.mt = CW'(mt); p.mr = CW'(mr); p.mb = CW'(mb);
    p.dx = CW'(dx); p.dy = CW'(dy);
    p.sl = CW'(sl); p.st = CW'(st); p.sr = CW'(sr); p.sb = CW'(sb);
    return p;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    contact_t miss;
    int i;
    miss = '0;

    // miss rows are typed in; everything else goes through the predictor
    r.fixed = 1; r.want = miss;
    r.p = '0; rows = {rows, r};                                         // all zero, no shift
    r.p = mk(0, 256, 256, 0, 0, 0, 0, 256, 256, 0); rows = {rows, r};   // overlap, no shift
    r.p = mk(0, 256, 256, 0, 256, 0, 4096, 256, 4352, 0); rows = {rows, r}; // broad miss x
    r.p = mk(0, 256, 256, 0, 0, 256, 0, 4096, 256, 3840); rows = {rows, r}; // broad miss y
    r.p = {CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN};
    rows = {rows, r};
    r.fixed = 0;
    r.p = mk(0, 256, 256, 0, 512, 0, 512, 256, 768, 0); rows = {rows, r};   // x, t=0.5
    r.p = mk(0, 256, 256, 0, 1024, 0, 512, 256, 768, 0); rows = {rows, r};  // x, t=0.25
    r.p = mk(1024, 256, 1280, 0, -1024, 0, 512, 256, 768, 0); rows = {rows, r}; // -x
    r.p = mk(0, 256, 256, 0, 0, 1024, 0, 768, 256, 512); rows = {rows, r};  // +y
    r.p = mk(0, 1280, 256, 1024, 0, -1024, 0, 768, 256, 512); rows = {rows, r}; // -y
    r.p = mk(0, 256, 256, 0, 512, 512, 512, 768, 768, 512); rows = {rows, r}; // tie
    r.p = mk(0, 256, 256, 0, 768, 300, 512, 400, 768, 0); rows = {rows, r}; // diagonal
    r.p = mk(0, 256, 256, 0, 100, 0, 0, 256, 256, 0); rows = {rows, r};   // start inside
    r.p = mk(256, 0, 0, 256, 512, 0, 512, 256, 768, 0); rows = {rows, r}; // inverted box
    r.p = mk(0, 256, 256, 0, 3, 0, 259, 256, 512, 0); rows = {rows, r};   // t = 1 exact
    r.p = mk(0, 256, 256, 0, 3, 0, 257, 256, 512, 0); rows = {rows, r};   // 1/3 truncation
    r.p = {CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}; rows = {rows, r};
    r.p = {CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}; rows = {rows, r};
    r.p = {CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN}; rows = {rows, r};
    r.p = {CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX}; rows = {rows, r};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[k]) send_pair(rows[k].p, rows[k].fixed, rows[k].want);
    // sender pause until every expected result is back
    drain();

    // long receiver hold-off while the sender keeps offering: pipeline fills
    hold_off = 3 * LATENCY;
    for (i = 0; i < 60; i++) send_pair(random_pair(), 1'b0, miss);
    drain();

    // idling phases: none, sender, receiver, both
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      unique case ((i * 4) / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      send_pair(random_pair(), 1'b0, miss);
    end
    recv_stall_pct = 0;
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/swa_pkg.sv
rtl/core/swept_aabb_collision.sv
rtl/core/swa_checker.sv
tb/sv/tb_swept_aabb_collision.sv
